// ===== rtl/fspa_pkg.sv =====
// Package for the fixed slot pool allocator.
// Widths, reset values, command and register codes, controller/datapath structs.
// No dependencies.
package fspa_pkg;

	localparam int BLOCK_SLOTS_DEF = 64;
	localparam int MAX_BLOCKS_DEF  = 16;

	localparam int SLOT_W     = 10;
	localparam int LINK_DEPTH = 1024;
	localparam int SPB_W      = 7;
	localparam int LIMIT_W    = 5;
	localparam int BLK_W      = 5;
	localparam int CNT_W      = 32;
	localparam int LEN_W      = 16;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [SPB_W-1:0]   SPB_RESET   = 7'd64;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOTS_PER_BLOCK = 1'b0,
		REG_BLOCK_LIMIT     = 1'b1
	} cfg_reg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic push;      // free: link the slot onto the list
		logic pop;       // allocate from the list: read the link of the head
		logic pop_done;  // link data is back: advance the head
		logic bump;      // allocate from the current block
		logic load_out;  // capture the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic list_nonempty;
	} dp_stat_t;

endpackage

// ===== rtl/fspa_in_if.sv =====
// Command channel of the slot pool allocator: valid/ready plus command payload.
// Depends on fspa_pkg.
interface fspa_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [fspa_pkg::SLOT_W-1:0] slot_in;

	modport source (output valid, output cmd, output slot_in, input ready);
	modport sink   (input valid, input cmd, input slot_in, output ready);
endinterface

// ===== rtl/fspa_out_if.sv =====
// Result channel of the slot pool allocator: valid/ready plus result and statistics.
// Depends on fspa_pkg.
interface fspa_out_if;
	logic                       valid;
	logic                       ready;
	logic                       ok;
	logic [fspa_pkg::SLOT_W-1:0]  slot_out;
	logic [fspa_pkg::CNT_W-1:0]   alloc_total;
	logic [fspa_pkg::CNT_W-1:0]   free_total;
	logic [fspa_pkg::BLK_W-1:0]   blocks_opened;
	logic [fspa_pkg::LEN_W-1:0]   free_list_count;

	modport source (output valid, output ok, output slot_out, output alloc_total,
		output free_total, output blocks_opened, output free_list_count, input ready);
	modport sink   (input valid, input ok, input slot_out, input alloc_total,
		input free_total, input blocks_opened, input free_list_count, output ready);
endinterface

// ===== rtl/fspa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module fspa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/fspa_ctrl.sv =====
// Controller of the slot pool allocator: handshake, pop sequencing, output valid.
// Depends on fspa_pkg.
module fspa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  fspa_pkg::dp_stat_t stat,
	output fspa_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   is_free;

	// Take a command only when the output register is empty or drains now
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_free  = (in_cmd == fspa_pkg::CMD_FREE);

	always_comb begin
		cmd.push     = accept && is_free;
		cmd.pop      = accept && !is_free && stat.list_nonempty;
		cmd.bump     = accept && !is_free && !stat.list_nonempty;
		cmd.pop_done = (state_q == S_POP);
		cmd.load_out = accept;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.pop) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/fspa_datapath.sv =====
// Datapath of the slot pool allocator: free list head, link RAM, bump pointer,
// block accounting, statistics and output register. Depends on fspa_pkg, fspa_ram.
module fspa_datapath #(
	parameter int BLOCK_SLOTS = fspa_pkg::BLOCK_SLOTS_DEF,
	parameter int MAX_BLOCKS  = fspa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fspa_pkg::dp_cmd_t                  cmd,
	output fspa_pkg::dp_stat_t                 stat,
	input  logic [fspa_pkg::SLOT_W-1:0]        slot_in,
	input  logic                               cfg_we,
	input  logic [fspa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fspa_pkg::CFG_W-1:0]         cfg_wdata,
	output logic                               ok,
	output logic [fspa_pkg::SLOT_W-1:0]        slot_out,
	output logic [fspa_pkg::CNT_W-1:0]         alloc_total,
	output logic [fspa_pkg::CNT_W-1:0]         free_total,
	output logic [fspa_pkg::BLK_W-1:0]         blocks_opened,
	output logic [fspa_pkg::LEN_W-1:0]         free_list_count
);

	logic [fspa_pkg::SPB_W-1:0]   cfg_spb_q;
	logic [fspa_pkg::LIMIT_W-1:0] cfg_limit_q;

	logic [fspa_pkg::SLOT_W-1:0] head_q;
	logic [fspa_pkg::BLK_W-1:0]  active_q;
	logic                        block_open_q;
	logic [fspa_pkg::SPB_W-1:0]  bump_q;
	logic [fspa_pkg::BLK_W-1:0]  opened_q;
	logic [fspa_pkg::CNT_W-1:0]  alloc_q;
	logic [fspa_pkg::CNT_W-1:0]  free_q;
	logic [fspa_pkg::LEN_W-1:0]  len_q;

	logic                        ok_q;
	logic [fspa_pkg::SLOT_W-1:0] slot_q;

	logic [fspa_pkg::SPB_W-1:0]   spb_eff;
	logic [fspa_pkg::LIMIT_W-1:0] limit_eff;
	logic                         need_new;
	logic                         have;
	logic [fspa_pkg::BLK_W-1:0]   blk_sel;
	logic [fspa_pkg::SPB_W-1:0]   off_sel;
	logic [31:0]                  handle_wide;
	logic [fspa_pkg::SLOT_W-1:0]  bump_slot;
	logic                         nonempty;
	logic [fspa_pkg::SLOT_W-1:0]  link_wdata;
	logic [fspa_pkg::SLOT_W-1:0]  link_rdata;
	logic                         ok_nxt;
	logic [fspa_pkg::SLOT_W-1:0]  slot_nxt;

	assign nonempty           = (len_q != '0);
	assign stat.list_nonempty = nonempty;
	assign link_wdata         = nonempty ? head_q : '0;

	fspa_ram #(
		.WIDTH (fspa_pkg::SLOT_W),
		.DEPTH (fspa_pkg::LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (slot_in),
		.wdata (link_wdata),
		.re    (cmd.pop),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	// Clamp the registers to the legal range
	always_comb begin
		spb_eff = cfg_spb_q;
		if (cfg_spb_q == '0) begin
			spb_eff = fspa_pkg::SPB_W'(1);
		end else if (32'(cfg_spb_q) > 32'(BLOCK_SLOTS)) begin
			spb_eff = fspa_pkg::SPB_W'(BLOCK_SLOTS);
		end
		limit_eff = cfg_limit_q;
		if (32'(cfg_limit_q) > 32'(MAX_BLOCKS)) begin
			limit_eff = fspa_pkg::LIMIT_W'(MAX_BLOCKS);
		end
	end

	always_comb begin
		need_new    = !block_open_q || (bump_q >= spb_eff);
		have        = !need_new || (opened_q < limit_eff);
		blk_sel     = need_new ? opened_q : active_q;
		off_sel     = need_new ? '0 : bump_q;
		handle_wide = 32'(blk_sel) * 32'(BLOCK_SLOTS) + 32'(off_sel);
		bump_slot   = handle_wide[fspa_pkg::SLOT_W-1:0];
	end

	always_comb begin
		ok_nxt   = 1'b0;
		slot_nxt = '0;
		priority if (cmd.push) begin
			ok_nxt   = 1'b1;
			slot_nxt = slot_in;
		end else if (cmd.pop) begin
			ok_nxt   = 1'b1;
			slot_nxt = head_q;
		end else if (cmd.bump && have) begin
			ok_nxt   = 1'b1;
			slot_nxt = bump_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_spb_q    <= fspa_pkg::SPB_RESET;
			cfg_limit_q  <= fspa_pkg::LIMIT_RESET;
			head_q       <= '0;
			active_q     <= '0;
			block_open_q <= 1'b0;
			bump_q       <= '0;
			opened_q     <= '0;
			alloc_q      <= '0;
			free_q       <= '0;
			len_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fspa_pkg::REG_SLOTS_PER_BLOCK: cfg_spb_q <= cfg_wdata;
					fspa_pkg::REG_BLOCK_LIMIT: cfg_limit_q <= cfg_wdata[fspa_pkg::LIMIT_W-1:0];
				endcase
			end
			if (cmd.push) begin
				head_q <= slot_in;
				free_q <= free_q + 1'b1;
				if (len_q != '1) begin
					len_q <= len_q + 1'b1;
				end
			end
			if (cmd.pop) begin
				len_q   <= len_q - 1'b1;
				alloc_q <= alloc_q + 1'b1;
			end
			if (cmd.pop_done) begin
				head_q <= link_rdata;
			end
			if (cmd.bump && have) begin
				alloc_q <= alloc_q + 1'b1;
				if (need_new) begin
					active_q     <= opened_q;
					opened_q     <= opened_q + 1'b1;
					block_open_q <= 1'b1;
					bump_q       <= fspa_pkg::SPB_W'(1);
				end else begin
					bump_q <= bump_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ok_q   <= ok_nxt;
			slot_q <= slot_nxt;
		end
	end

	// Statistics only move on a transfer that also reloads the output register
	assign ok              = ok_q;
	assign slot_out        = slot_q;
	assign alloc_total     = alloc_q;
	assign free_total      = free_q;
	assign blocks_opened   = opened_q;
	assign free_list_count = len_q;

endmodule

// ===== rtl/fixed_slot_pool_allocator.sv =====
// Fixed slot pool allocator, top level. Depends on fspa_pkg, fspa_in_if, fspa_out_if,
// fspa_ctrl, fspa_datapath, fspa_ram.
// The result is registered and shows in the cycle after the command transfer.
// After a free or a bump allocate the controller stays idle; an allocate from the free
// list holds off the next command in S_POP while the link RAM read returns the next head.
// Reset (arst_n low): free list empty, no block open, counters zero, registers 64 and 16.
module fixed_slot_pool_allocator #(
	parameter int BLOCK_SLOTS = fspa_pkg::BLOCK_SLOTS_DEF,
	parameter int MAX_BLOCKS  = fspa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fspa_in_if.sink                        in_ch,
	fspa_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fspa_pkg::CFG_W-1:0]     cfg_wdata
);

	fspa_pkg::dp_cmd_t  dp_cmd;
	fspa_pkg::dp_stat_t dp_stat;

	// Controller: owns the handshake on both channels. A command transfer is
	// taken only when the output register is free or drains in the same cycle,
	// so the output register alone parts the two sides. A list pop holds off
	// the next transfer in the S_POP state while the link RAM returns the new head.
	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Datapath: a free pushes the slot (its link goes to RAM), an allocate pops
	// the list head, or, with the list empty, bumps through the open block and
	// opens a new one when none is open or the block is used up and the block limit allows.
	fspa_datapath #(
		.BLOCK_SLOTS (BLOCK_SLOTS),
		.MAX_BLOCKS  (MAX_BLOCKS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.slot_in         (in_ch.slot_in),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.ok              (out_ch.ok),
		.slot_out        (out_ch.slot_out),
		.alloc_total     (out_ch.alloc_total),
		.free_total      (out_ch.free_total),
		.blocks_opened   (out_ch.blocks_opened),
		.free_list_count (out_ch.free_list_count)
	);

	// Every command transfer produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> out_ch.valid)
		else $error("no result after command transfer");

	// A failed allocate reports handle zero
	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ok |-> out_ch.slot_out == '0)
		else $error("failed allocate with nonzero handle");

	// After a free, the list is not empty
	a_free_fills_list: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.cmd == fspa_pkg::CMD_FREE
		|=> out_ch.free_list_count != '0)
		else $error("free list empty after free");

	// A list pop blocks the next transfer while the head is reloaded
	a_pop_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.cmd == fspa_pkg::CMD_ALLOC
		&& dp_stat.list_nonempty |=> !in_ch.ready)
		else $error("transfer taken during list pop");

endmodule
